@@ hdl/stffa_pkg.sv @@
// Package for the sprite tile first-fit allocator.
// Beat structs, cell control struct, tile-count table and shared constants.
// No dependencies.
package stffa_pkg;

   localparam int MAX_REGIONS_DEF = 128;
   localparam int TILE_TOTAL      = 1024;
   localparam int TILE_W          = 10;   // tile number
   localparam int END_W           = 11;   // start + length
   localparam int CAND_W          = 12;   // aligned candidate start
   localparam int SUM_W           = 13;   // candidate + count
   localparam int LEN_W           = 8;
   localparam int OWNER_W         = 16;
   localparam int LEFT_W          = 11;

   localparam logic CMD_ALLOC  = 1'b0;
   localparam logic CMD_LOOKUP = 1'b1;

   localparam logic [2:0] CSR_ADDR_BITMAP = 3'd0;

   typedef struct packed {
      logic                 cmd;
      logic [1:0]           shape_code;
      logic [1:0]           sprite_size_class;
      logic                 eight_bpp;
      logic [OWNER_W-1:0]   owner_id;
      logic [TILE_W-1:0]    lookup_tile;
   } req_type;

   typedef struct packed {
      logic [TILE_W-1:0]    first_tile;
      logic                 alloc_failed;
      logic                 found;
      logic [OWNER_W-1:0]   owner_out;
      logic [LEFT_W-1:0]    tiles_left;
   } rsp_type;

   typedef struct packed {
      logic [TILE_W-1:0]    start;
      logic [LEN_W-1:0]     len;
      logic [OWNER_W-1:0]   owner;
   } entry_type;

   typedef struct packed {
      logic shift;   // take the left neighbor's entry
      logic load;    // take the new entry
   } cell_ctl_type;

   // tiles for shape/size at 4bpp, doubled for 8bpp; zero for shape three
   function automatic logic [LEN_W-1:0] tiles_for_shape(input logic [1:0] shape,
                                                        input logic [1:0] size_class,
                                                        input logic       bpp8);
      logic [LEN_W-1:0] base;
      base = '0;
      case (shape)
         2'd0: begin
            case (size_class)
               2'd0:    base = 8'd1;
               2'd1:    base = 8'd4;
               2'd2:    base = 8'd16;
               default: base = 8'd64;
            endcase
         end
         2'd1, 2'd2: begin
            case (size_class)
               2'd0:    base = 8'd2;
               2'd1:    base = 8'd4;
               2'd2:    base = 8'd8;
               default: base = 8'd32;
            endcase
         end
         default: base = '0;
      endcase
      return bpp8 ? {base[LEN_W-2:0], 1'b0} : base;
   endfunction

endpackage

@@ hdl/sprite_tile_first_fit_allocator_core.sv @@
// Top level of the sprite tile first-fit allocator: FSM, token scan,
// cell chain and CSR. Depends on stffa_pkg and stffa_cell.
//
//  channel | ports        | beat
//  --------+--------------+-------------------------------------
//  input   | req_*        | req_type: allocate or lookup
//  result  | rsp_*        | rsp_type: one per input beat
//  config  | csr_*        | APB write/read of bitmap_mode_active
//
// A token walks the cell chain one cell per cycle from cell 0.
// Lookup stops at the hit cell, or after the last valid region on a miss.
// Allocate takes the first fitting gap, else the tail after the last region, else fails;
// shape three or a full table fails before the token moves.
// Insert loads the new entry and shifts all later cells right together.
// Reset clears the region count and tile usage; cells need no clearing.
// A stalled result holds the FSM in FINISH, adding the stall cycles; input stalls while busy.
module sprite_tile_first_fit_allocator_core
   import stffa_pkg::*;
#(
   parameter int MAX_REGIONS = MAX_REGIONS_DEF
)(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  req_type       req_data,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output rsp_type       rsp_data,
   input  logic          csr_psel,
   input  logic          csr_penable,
   input  logic          csr_pwrite,
   input  logic [2:0]    csr_paddr,
   input  logic [31:0]   csr_pwdata,
   output logic [31:0]   csr_prdata,
   output logic          csr_pready
);

   localparam int IW = $clog2(MAX_REGIONS);
   localparam int CW = $clog2(MAX_REGIONS + 1);

   typedef enum logic [2:0] {IDLE, SCAN, TAIL, INSERT, FINISH} state_type;

   state_type              state_ff;
   req_type                req_ff;
   logic [LEN_W-1:0]       count_ff;
   logic [MAX_REGIONS-1:0] token_ff;
   logic [IW-1:0]          idx_ff;
   logic [CW-1:0]          total_ff;
   logic [LEFT_W-1:0]      used_ff;
   logic [IW-1:0]          pos_ff;
   logic [TILE_W-1:0]      cand_ff;
   logic                   failed_ff;
   logic                   found_ff;
   logic [OWNER_W-1:0]     owner_res_ff;
   logic [TILE_W-1:0]      start_res_ff;
   logic                   bitmap_ff;
   logic                   rsp_valid_ff;
   rsp_type                rsp_ff;

   entry_type              cell_entry [MAX_REGIONS];
   logic [END_W-1:0]       cell_end   [MAX_REGIONS];
   logic [MAX_REGIONS-1:0] cell_fit;
   logic [MAX_REGIONS-1:0] cell_match;
   logic [MAX_REGIONS-1:0] cell_valid;
   cell_ctl_type           cell_ctl   [MAX_REGIONS];
   entry_type              new_entry;

   logic                   sel_fit;
   logic                   sel_match;
   logic                   sel_valid;
   logic [OWNER_W-1:0]     sel_owner;
   logic [END_W-1:0]       sel_end;
   logic [END_W-1:0]       low_tile;
   logic [END_W-1:0]       tail_floor;
   logic [CAND_W-1:0]      tail_cand;
   logic [SUM_W-1:0]       tail_need;
   logic [CAND_W-1:0]      gap_cand;
   logic [END_W-1:0]       gap_floor;
   logic [LEFT_W-1:0]      limit;
   logic [LEFT_W-1:0]      free_tiles;
   logic                   csr_write;

   assign low_tile  = bitmap_ff ? END_W'(TILE_TOTAL / 2 + 1) : END_W'(1);
   assign limit     = bitmap_ff ? LEFT_W'(TILE_TOTAL / 2) : LEFT_W'(TILE_TOTAL);
   assign free_tiles = (used_ff >= limit) ? '0 : limit - used_ff;

   assign new_entry.start = cand_ff;
   assign new_entry.len   = count_ff;
   assign new_entry.owner = req_ff.owner_id;

   // cell controls and token-selected readout
   always_comb begin
      sel_fit   = 1'b0;
      sel_match = 1'b0;
      sel_valid = 1'b0;
      sel_owner = '0;
      sel_end   = '0;
      for (int k = 0; k < MAX_REGIONS; k++) begin
         cell_valid[k] = CW'(k) < total_ff;
         cell_ctl[k].load  = (state_ff == INSERT) && (IW'(k) == pos_ff);
         cell_ctl[k].shift = (state_ff == INSERT) && (IW'(k) > pos_ff)
                             && (CW'(k) <= total_ff);
         sel_fit   = sel_fit   | (token_ff[k] & cell_fit[k]);
         sel_match = sel_match | (token_ff[k] & cell_match[k]);
         sel_valid = sel_valid | (token_ff[k] & cell_valid[k]);
         sel_owner = sel_owner | ({OWNER_W{token_ff[k]}} & cell_entry[k].owner);
         sel_end   = sel_end   | ({END_W{token_ff[k]}} & cell_end[k]);
      end
   end

   // candidate at the end of the token cell
   assign gap_floor = (sel_end < low_tile) ? low_tile : sel_end;
   assign gap_cand  = CAND_W'(gap_floor) + CAND_W'(gap_floor[0] & req_ff.eight_bpp);

   // tail candidate: after the last region, or from the floor when empty
   assign tail_floor = (total_ff == '0) ? low_tile :
                       ((sel_end < low_tile) ? low_tile : sel_end);
   assign tail_cand  = CAND_W'(tail_floor) + CAND_W'(tail_floor[0] & req_ff.eight_bpp);
   assign tail_need  = SUM_W'(tail_cand) + SUM_W'(count_ff);

   for (genvar g = 0; g < MAX_REGIONS; g++) begin : g_cell
      stffa_cell u_cell (
         .clock      (clock),
         .ctl        (cell_ctl[g]),
         .left_entry ((g == 0) ? new_entry : cell_entry[(g == 0) ? 0 : g - 1]),
         .new_entry  (new_entry),
         .valid      (cell_valid[g]),
         .next_valid ((g == MAX_REGIONS - 1) ? 1'b0
                      : cell_valid[(g == MAX_REGIONS - 1) ? g : g + 1]),
         .next_start (cell_entry[(g == MAX_REGIONS - 1) ? g : g + 1].start),
         .low_tile   (low_tile),
         .bpp8       (req_ff.eight_bpp),
         .count      (count_ff),
         .look_tile  (req_ff.lookup_tile),
         .entry      (cell_entry[g]),
         .end_tile   (cell_end[g]),
         .fit        (cell_fit[g]),
         .match      (cell_match[g])
      );
   end

   assign req_stall = (state_ff != IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         total_ff     <= '0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         token_ff     <= '0;
         idx_ff       <= '0;
      end else begin
         // FINISH drives the result valid itself
         if (state_ff != FINISH && rsp_valid_ff && !rsp_stall)
            rsp_valid_ff <= 1'b0;
         case (state_ff)
            IDLE: begin
               if (req_valid) begin
                  req_ff       <= req_data;
                  count_ff     <= tiles_for_shape(req_data.shape_code,
                                                  req_data.sprite_size_class,
                                                  req_data.eight_bpp);
                  token_ff     <= MAX_REGIONS'(1);
                  idx_ff       <= '0;
                  failed_ff    <= (req_data.cmd == CMD_ALLOC);
                  found_ff     <= 1'b0;
                  owner_res_ff <= '0;
                  start_res_ff <= '0;
                  state_ff     <= SCAN;
               end
            end
            SCAN: begin
               if (req_ff.cmd == CMD_LOOKUP) begin
                  if (!sel_valid) begin
                     state_ff <= FINISH;
                  end else if (sel_match) begin
                     found_ff     <= 1'b1;
                     owner_res_ff <= sel_owner;
                     state_ff     <= FINISH;
                  end else if (idx_ff == IW'(MAX_REGIONS - 1)) begin
                     state_ff <= FINISH;
                  end else begin
                     token_ff <= {token_ff[MAX_REGIONS-2:0], 1'b0};
                     idx_ff   <= idx_ff + IW'(1);
                  end
               end else if (count_ff == '0 || total_ff == CW'(MAX_REGIONS)) begin
                  state_ff <= FINISH;
               end else if (CW'(idx_ff) + CW'(1) >= total_ff) begin
                  state_ff <= TAIL;
               end else if (sel_fit) begin
                  cand_ff  <= gap_cand[TILE_W-1:0];
                  pos_ff   <= idx_ff + IW'(1);
                  state_ff <= INSERT;
               end else begin
                  token_ff <= {token_ff[MAX_REGIONS-2:0], 1'b0};
                  idx_ff   <= idx_ff + IW'(1);
               end
            end
            TAIL: begin
               if (free_tiles >= LEFT_W'(count_ff) &&
                   tail_need <= SUM_W'(TILE_TOTAL)) begin
                  cand_ff  <= tail_cand[TILE_W-1:0];
                  pos_ff   <= total_ff[IW-1:0];
                  state_ff <= INSERT;
               end else begin
                  state_ff <= FINISH;
               end
            end
            INSERT: begin
               total_ff     <= total_ff + CW'(1);
               used_ff      <= used_ff + LEFT_W'(count_ff);
               failed_ff    <= 1'b0;
               start_res_ff <= cand_ff;
               state_ff     <= FINISH;
            end
            FINISH: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= IDLE;
               end
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == FINISH && (!rsp_valid_ff || !rsp_stall)) begin
         rsp_ff.first_tile   <= start_res_ff;
         rsp_ff.alloc_failed <= failed_ff;
         rsp_ff.found        <= found_ff;
         rsp_ff.owner_out    <= owner_res_ff;
         rsp_ff.tiles_left   <= free_tiles;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // CSR
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset)
         bitmap_ff <= 1'b0;
      else if (csr_write && csr_paddr[2] == CSR_ADDR_BITMAP[2])
         bitmap_ff <= csr_pwdata[0];
   end

   assign csr_prdata = (csr_paddr[2] == CSR_ADDR_BITMAP[2]) ? {31'b0, bitmap_ff} : '0;

`ifndef SYNTH
   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      total_ff <= CW'(MAX_REGIONS))
      else $error("region count above table size");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      state_ff == INSERT |=> total_ff == $past(total_ff) + CW'(1))
      else $error("insert did not grow the table");

   a_lookup_no_insert: assert property (@(posedge clock) disable iff (reset)
      (state_ff == INSERT) |-> (req_ff.cmd == CMD_ALLOC))
      else $error("lookup reached insert");

   a_token_onehot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == SCAN) |-> $onehot(token_ff))
      else $error("scan token not one-hot");
`endif

endmodule

@@ hdl/stffa_cell.sv @@
// One table cell: holds a region entry, tests the gap to its right neighbor
// and matches a lookup tile. Depends on stffa_pkg.
module stffa_cell
   import stffa_pkg::*;
(
   input  logic                clock,
   input  cell_ctl_type        ctl,
   input  entry_type           left_entry,
   input  entry_type           new_entry,
   input  logic                valid,
   input  logic                next_valid,
   input  logic [TILE_W-1:0]   next_start,
   input  logic [END_W-1:0]    low_tile,
   input  logic                bpp8,
   input  logic [LEN_W-1:0]    count,
   input  logic [TILE_W-1:0]   look_tile,
   output entry_type           entry,
   output logic [END_W-1:0]    end_tile,
   output logic                fit,
   output logic                match
);

   entry_type          entry_ff;
   entry_type          entry_in;
   logic [END_W-1:0]   floor_c;
   logic [CAND_W-1:0]  cand;
   logic [SUM_W-1:0]   need;

   always_comb begin
      entry_in = entry_ff;
      if (ctl.load)
         entry_in = new_entry;
      else if (ctl.shift)
         entry_in = left_entry;
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign end_tile = END_W'(entry_ff.start) + END_W'(entry_ff.len);
   assign floor_c  = (end_tile < low_tile) ? low_tile : end_tile;
   assign cand     = CAND_W'(floor_c) + CAND_W'(floor_c[0] & bpp8);
   assign need     = SUM_W'(cand) + SUM_W'(count);
   assign fit      = valid & next_valid & (need <= SUM_W'(next_start));
   assign match    = valid & (entry_ff.start == look_tile);
   assign entry    = entry_ff;

endmodule

@@ sim/sprite_tile_first_fit_allocator_core_tb.sv @@
// Self-checking bench for the sprite tile first-fit allocator core.
// Directed table then random allocate/lookup beats, scored against an in-bench
// region table model. Depends on stffa_pkg and the core RTL.
module sprite_tile_first_fit_allocator_core_tb
   import stffa_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NREG     = MAX_REGIONS_DEF;
   localparam int WATCHDOG = 20000;
   localparam int N_RANDOM = 1700;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   always #6 clock = ~clock;

   sprite_tile_first_fit_allocator_core DUT (.*);

   // predictor state
   int          tbl_start[NREG];
   int          tbl_len[NREG];
   int          tbl_owner[NREG];
   int          tbl_count;
   int          tbl_used;
   bit          bitmap_mode;

   rsp_type     pending_rsp[$];
   int          mismatches;
   int          rsp_seen;
   int          idle_cycles;
   int          send_idle_pct, stall_pct;
   bit          timed_out;

   function automatic int reserved_half();
      return bitmap_mode ? TILE_TOTAL / 2 : 0;
   endfunction

   function automatic int tiles_free();
      int lim;
      lim = TILE_TOTAL - reserved_half();
      return (tbl_used >= lim) ? 0 : lim - tbl_used;
   endfunction

   function automatic int align_start(int tail_end, bit bpp8);
      int c;
      c = (tail_end < reserved_half() + 1) ? reserved_half() + 1 : tail_end;
      return c + (c & int'(bpp8));
   endfunction

   function automatic int tiles_needed(logic [1:0] shape, logic [1:0] sz, bit bpp8);
      int b;
      b = 0;
      if (shape == 2'd0) b = (sz == 0) ? 32 : (sz == 1) ? 128 : (sz == 2) ? 512 : 2048;
      else if (shape != 2'd3) b = (sz == 0) ? 64 : (sz == 1) ? 128 : (sz == 2) ? 256 : 1024;
      return (b << bpp8) >> 5;
   endfunction

   function automatic void table_insert(int pos, int st, int len, int own);
      for (int k = tbl_count; k > pos; k--) begin
         tbl_start[k] = tbl_start[k-1];
         tbl_len[k]   = tbl_len[k-1];
         tbl_owner[k] = tbl_owner[k-1];
      end
      tbl_start[pos] = st;
      tbl_len[pos]   = len;
      tbl_owner[pos] = own;
      tbl_count++;
      tbl_used += len;
   endfunction

   function automatic rsp_type predict_alloc(req_type r);
      rsp_type o;
      int cnt, c, tail_end;
      bit done;
      o = '0;
      done = 0;
      if (r.cmd == CMD_LOOKUP) begin
         for (int i = 0; i < tbl_count; i++)
            if (tbl_start[i] == r.lookup_tile) begin
               o.found = 1'b1;
               o.owner_out = 16'(tbl_owner[i]);
               break;
            end
      end else begin
         cnt = tiles_needed(r.shape_code, r.sprite_size_class, r.eight_bpp);
         o.alloc_failed = 1'b1;
         if (cnt != 0 && tbl_count < NREG) begin
            for (int i = 0; i + 1 < tbl_count; i++) begin
               c = align_start(tbl_start[i] + tbl_len[i], r.eight_bpp);
               if (c + cnt <= tbl_start[i+1]) begin
                  table_insert(i + 1, c, cnt, r.owner_id);
                  o.first_tile = 10'(c);
                  done = 1;
                  break;
               end
            end
            if (!done) begin
               tail_end = (tbl_count != 0) ? tbl_start[tbl_count-1] + tbl_len[tbl_count-1] : 0;
               c = align_start(tail_end, r.eight_bpp);
               if (tiles_free() >= cnt && c + cnt <= TILE_TOTAL) begin
                  table_insert(tbl_count, c, cnt, r.owner_id);
                  o.first_tile = 10'(c);
                  done = 1;
               end
            end
            if (done) o.alloc_failed = 1'b0;
         end
      end
      o.tiles_left = 11'(tiles_free());
      return o;
   endfunction

   // result checker and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (rsp_valid && !rsp_stall) begin
            rsp_seen++;
            if (pending_rsp.size() == 0) begin
               if (mismatches < 10) $display("unexpected result beat %p", rsp_data);
               mismatches++;
            end else begin
               if (rsp_data !== pending_rsp[0]) begin
                  if (mismatches < 10)
                     $display("mismatch: expected %p got %p", pending_rsp[0], rsp_data);
                  mismatches++;
               end
               void'(pending_rsp.pop_front());
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   task automatic csr_write(bit val);
      @(posedge clock);
      csr_psel <= 1'b1; csr_pwrite <= 1'b1; csr_paddr <= CSR_ADDR_BITMAP;
      csr_pwdata <= {31'd0, val};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      bitmap_mode = val;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0 && !timed_out) begin
         @(posedge clock);
         if (idle_cycles > WATCHDOG) timed_out = 1;
      end
      repeat (300) @(posedge clock);
   endtask

   // fixed rows are checked against the predictor before the beat goes out;
   // valid stays high into the next beat unless the sender idles
   task automatic send_beat(req_type r, bit has_fixed, rsp_type fixed);
      rsp_type p;
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      p = predict_alloc(r);
      if (has_fixed && p !== fixed) begin
         if (mismatches < 10)
            $display("table row disagrees with predictor: %p vs %p", fixed, p);
         mismatches++;
      end
      pending_rsp.push_back(p);
      req_data <= r;
      req_valid <= 1'b1;
      do begin
         @(posedge clock);
         if (idle_cycles > WATCHDOG) timed_out = 1;
      end while (req_stall && !timed_out);
   endtask

   function automatic req_type mk(int cmd, int sh, int sz, int b8, int own, int lk);
      req_type r;
      r.cmd = 1'(cmd); r.shape_code = 2'(sh); r.sprite_size_class = 2'(sz);
      r.eight_bpp = 1'(b8); r.owner_id = 16'(own); r.lookup_tile = 10'(lk);
      return r;
   endfunction

   function automatic rsp_type mkr(int st, int f, int fd, int own, int left);
      rsp_type o;
      o.first_tile = 10'(st); o.alloc_failed = 1'(f); o.found = 1'(fd);
      o.owner_out = 16'(own); o.tiles_left = 11'(left);
      return o;
   endfunction

   typedef struct {
      req_type r;
      bit      fixed;
      rsp_type o;
   } stim_row_type;

   task automatic random_phase(int n, int sidle, int rstall);
      req_type r;
      send_idle_pct = sidle;
      stall_pct = rstall;
      for (int i = 0; i < n && !timed_out; i++) begin
         r = req_type'($urandom);
         if ($urandom_range(99) < 45) begin
            r.cmd = CMD_ALLOC;
            // favor small sizes so the table fills deep
            if ($urandom_range(9) < 7) r.sprite_size_class = 2'($urandom_range(1));
            if ($urandom_range(19) == 0) r.shape_code = 2'd3;
            else r.shape_code = 2'($urandom_range(2));
         end else begin
            r.cmd = CMD_LOOKUP;
            if (tbl_count != 0 && $urandom_range(99) < 70)
               r.lookup_tile = 10'(tbl_start[$urandom_range(tbl_count - 1)]);
         end
         send_beat(r, 1'b0, '0);
      end
      send_idle_pct = 0;
      stall_pct = 0;
      drain_results();
   endtask

   stim_row_type dir_rows[$];

   initial begin
      tbl_count = 0; tbl_used = 0; bitmap_mode = 0;
      mismatches = 0; rsp_seen = 0; idle_cycles = 0;
      send_idle_pct = 0; stall_pct = 0; timed_out = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      dir_rows.push_back('{mk(CMD_LOOKUP, 0, 0, 0, 16'hFFFF, 10'd0), 1, mkr(0, 0, 0, 0, 1024)});
      dir_rows.push_back('{mk(CMD_ALLOC, 3, 0, 0, 16'h1234, 0), 1, mkr(0, 1, 0, 0, 1024)});
      dir_rows.push_back('{mk(CMD_ALLOC, 0, 0, 0, 16'h0000, 0), 1, mkr(1, 0, 0, 0, 1023)});
      dir_rows.push_back('{mk(CMD_ALLOC, 0, 0, 1, 16'hFFFF, 0), 1, mkr(2, 0, 0, 0, 1021)});
      dir_rows.push_back('{mk(CMD_LOOKUP, 0, 0, 0, 0, 10'd2), 1, mkr(0, 0, 1, 16'hFFFF, 1021)});
      dir_rows.push_back('{mk(CMD_LOOKUP, 0, 0, 0, 0, 10'd1023), 1, mkr(0, 0, 0, 0, 1021)});
      dir_rows.push_back('{mk(CMD_ALLOC, 0, 3, 1, 16'hA5A5, 0), 0, '0});
      dir_rows.push_back('{mk(CMD_ALLOC, 1, 3, 1, 16'h5A5A, 0), 0, '0});
      dir_rows.push_back('{mk(CMD_ALLOC, 2, 3, 0, 16'h0F0F, 0), 0, '0});
      dir_rows.push_back('{mk(CMD_ALLOC, 1, 1, 0, 16'h0001, 0), 0, '0});
      dir_rows.push_back('{mk(CMD_ALLOC, 2, 2, 1, 16'h8000, 0), 0, '0});
      dir_rows.push_back('{mk(CMD_ALLOC, 0, 2, 0, 16'h7FFF, 0), 0, '0});
      dir_rows.push_back('{mk(CMD_ALLOC, 0, 3, 1, 16'hBEEF, 0), 0, '0});
      dir_rows.push_back('{mk(CMD_ALLOC, 0, 3, 1, 16'hCAFE, 0), 0, '0});
      dir_rows.push_back('{mk(CMD_LOOKUP, 3, 3, 1, 16'hFFFF, 10'd3), 0, '0});
      foreach (dir_rows[i]) send_beat(dir_rows[i].r, dir_rows[i].fixed, dir_rows[i].o);
      drain_results();

      // mode switched with regions present: free count floors at zero
      csr_write(1'b1);
      send_beat(mk(CMD_ALLOC, 0, 0, 1, 16'h4242, 0), 0, '0);
      send_beat(mk(CMD_LOOKUP, 0, 0, 0, 0, 10'd513), 0, '0);
      drain_results();

      random_phase(N_RANDOM / 4, 0, 0);
      csr_write(1'b0);
      random_phase(N_RANDOM / 4, 60, 0);
      csr_write(1'b1);
      random_phase(N_RANDOM / 4, 0, 60);
      csr_write(1'b0);
      random_phase(N_RANDOM / 4, 24, 24);

      if (timed_out) begin
         $display("sprite_tile_first_fit_allocator_core test failed");
      end else begin
         $display("covered %0d result beats over directed rows and four idle/stall phases",
                  rsp_seen);
         $display("bitmap mode toggled between phases; final table holds %0d regions",
                  tbl_count);
         if (mismatches == 0 && pending_rsp.size() == 0)
            $display("sprite_tile_first_fit_allocator_core test passed");
         else
            $display("sprite_tile_first_fit_allocator_core test failed");
      end
      $finish;
   end

endmodule

@@ sim.f @@
hdl/stffa_pkg.sv
hdl/stffa_cell.sv
hdl/sprite_tile_first_fit_allocator_core.sv
sim/sprite_tile_first_fit_allocator_core_tb.sv
